### sv/sis_pkg.sv
package sis_pkg;

   localparam int DATA_W       = 32;
   localparam int MODE_W       = 3;
   localparam int CAPACITY_DEF = 16;

   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SORTED = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_CLEAR,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic [1:0] {
      INS_TAIL,
      INS_HEAD,
      INS_SORTED
   } ins_kind_type;

   typedef struct packed {
      cell_op_type               op;
      ins_kind_type              kind;
      logic signed [DATA_W-1:0]  value;
      logic signed [DATA_W-1:0]  head;
   } cell_cmd_type;

endpackage

### sv/sis_cell.sv
module sis_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  sis_pkg::cell_cmd_type             cmd,
   input  logic                              after_left,
   input  logic                              occ_left,
   input  logic signed [sis_pkg::DATA_W-1:0] data_left,
   input  logic                              occ_right,
   input  logic signed [sis_pkg::DATA_W-1:0] data_right,
   output logic                              after,
   output logic                              occ,
   output logic signed [sis_pkg::DATA_W-1:0] data
);

   logic signed [sis_pkg::DATA_W-1:0] data_ff;
   logic signed [sis_pkg::DATA_W-1:0] data_in;
   logic                              occ_ff;
   logic                              occ_in;
   logic                              less;
   logic                              stop;

   assign less = data_ff < cmd.value;

   // insert point: first cell where this one stops the search
   always_comb begin
      unique case (cmd.kind)
         sis_pkg::INS_TAIL:   stop = !occ_ff;
         sis_pkg::INS_HEAD:   stop = 1'b1;
         sis_pkg::INS_SORTED: stop = !occ_ff || !less;
         default:             stop = 1'b1;
      endcase
   end

   assign after = after_left | stop;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      unique case (cmd.op)
         sis_pkg::CELL_INSERT: begin
            if (after && !after_left) begin
               data_in = cmd.value;
            end else if (after_left) begin
               data_in = data_left;
            end
            occ_in = occ_ff | occ_left;
         end
         sis_pkg::CELL_CLEAR: begin
            occ_in = 1'b0;
         end
         sis_pkg::CELL_ROTATE: begin
            // occupied region turns by one, tail picks up the old head
            if (occ_right) begin
               data_in = data_right;
            end else if (occ_ff) begin
               data_in = cmd.head;
            end
         end
         sis_pkg::CELL_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign occ  = occ_ff;
   assign data = data_ff;

endmodule

### sv/sorted_insert_sequence_store_core.sv
// latency: append, head insert, sorted insert, clear and unknown modes give one result
//   on the cycle after start is taken; busy stays low, so one command per cycle
// read out: an empty store answers on the next cycle; otherwise busy is high from the cycle after start
//   while the stored elements are rotated out, and each element follows in the next cycle, one per cycle
// reset: count and occupancy cleared, element contents undefined until written
// the receiver cannot stall: each result strobe lasts exactly one cycle
module sorted_insert_sequence_store_core #(
   parameter int CAPACITY = sis_pkg::CAPACITY_DEF,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sis_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [sis_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic signed [sis_pkg::DATA_W-1:0]   rsp_element,
   output logic                                rsp_element_valid,
   output logic [CNT_W-1:0]                    rsp_count,
   output logic                                rsp_status,
   output logic                                rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                         state_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  rd_left_ff;
   logic                              rsp_strobe_ff;
   logic signed [sis_pkg::DATA_W-1:0] rsp_element_ff;
   logic                              rsp_element_valid_ff;
   logic [CNT_W-1:0]                  rsp_count_ff;
   logic                              rsp_status_ff;
   logic                              rsp_last_ff;

   sis_pkg::cell_cmd_type             cmd;
   logic                              accept;
   logic                              full;

   logic [CAPACITY:0]                 after_c;
   logic [CAPACITY:0]                 occ_c;
   logic signed [sis_pkg::DATA_W-1:0] data_c [CAPACITY+1];
   logic [CAPACITY-1:0]               occ_v;

   assign busy   = (state_ff == ST_READ);
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      cmd.op    = sis_pkg::CELL_HOLD;
      cmd.kind  = sis_pkg::INS_TAIL;
      cmd.value = req_value;
      cmd.head  = data_c[0];
      if (state_ff == ST_READ) begin
         cmd.op = sis_pkg::CELL_ROTATE;
      end else if (accept) begin
         unique case (req_mode)
            sis_pkg::MODE_APPEND: begin
               cmd.op   = full ? sis_pkg::CELL_HOLD : sis_pkg::CELL_INSERT;
               cmd.kind = sis_pkg::INS_TAIL;
            end
            sis_pkg::MODE_HEAD: begin
               cmd.op   = full ? sis_pkg::CELL_HOLD : sis_pkg::CELL_INSERT;
               cmd.kind = sis_pkg::INS_HEAD;
            end
            sis_pkg::MODE_SORTED: begin
               cmd.op   = full ? sis_pkg::CELL_HOLD : sis_pkg::CELL_INSERT;
               cmd.kind = sis_pkg::INS_SORTED;
            end
            sis_pkg::MODE_CLEAR: cmd.op = sis_pkg::CELL_CLEAR;
            default:             cmd.op = sis_pkg::CELL_HOLD;
         endcase
      end
   end

   // cell chain: index 0 is the head; the extra slot closes the right end
   assign after_c[0] = 1'b0;
   assign occ_c[CAPACITY] = 1'b0;
   assign data_c[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                              occ_l;
      logic signed [sis_pkg::DATA_W-1:0] data_l;
      if (i == 0) begin : g_head
         assign occ_l  = 1'b1;
         assign data_l = '0;
      end else begin : g_body
         assign occ_l  = occ_c[i-1];
         assign data_l = data_c[i-1];
      end
      sis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .after_left (after_c[i]),
         .occ_left   (occ_l),
         .data_left  (data_l),
         .occ_right  (occ_c[i+1]),
         .data_right (data_c[i+1]),
         .after      (after_c[i+1]),
         .occ        (occ_c[i]),
         .data       (data_c[i])
      );
   end

   assign occ_v = occ_c[CAPACITY-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_left_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_strobe_ff        <= 1'b1;
                  rsp_element_ff       <= '0;
                  rsp_element_valid_ff <= 1'b0;
                  rsp_status_ff        <= 1'b0;
                  rsp_last_ff          <= 1'b1;
                  rsp_count_ff         <= count_ff;
                  unique case (req_mode)
                     sis_pkg::MODE_APPEND, sis_pkg::MODE_HEAD, sis_pkg::MODE_SORTED: begin
                        if (full) begin
                           rsp_status_ff <= 1'b1;
                        end else begin
                           count_ff     <= count_ff + 1'b1;
                           rsp_count_ff <= count_ff + 1'b1;
                        end
                     end
                     sis_pkg::MODE_CLEAR: begin
                        count_ff     <= '0;
                        rsp_count_ff <= '0;
                     end
                     sis_pkg::MODE_READ: begin
                        if (count_ff != '0) begin
                           // no result yet; the first element is registered in ST_READ
                           rsp_strobe_ff <= 1'b0;
                           rd_left_ff    <= count_ff;
                           state_ff      <= ST_READ;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_strobe_ff        <= 1'b1;
               rsp_element_ff       <= data_c[0];
               rsp_element_valid_ff <= 1'b1;
               rsp_count_ff         <= count_ff;
               rsp_status_ff        <= 1'b0;
               rsp_last_ff          <= (rd_left_ff == CNT_W'(1));
               rd_left_ff           <= rd_left_ff - 1'b1;
               if (rd_left_ff == CNT_W'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_valid = rsp_element_valid_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");

   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_v) == int'(count_ff))
      else $error("cell occupancy disagrees with stored count");

   a_stream_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("read out stream broken before last element");

   a_read_leaves_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> $stable(count_ff))
      else $error("count changed during read out");

endmodule

### tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = sis_pkg::CAPACITY_DEF;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int MODE_W   = sis_pkg::MODE_W;
   localparam int DATA_W   = sis_pkg::DATA_W;

   // modes above read out are unused and must leave the store alone
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_W'(sis_pkg::MODE_READ + 1);
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

   typedef struct {
      logic signed [DATA_W-1:0] element;
      logic                     element_valid;
      logic [CNT_W-1:0]         count;
      logic                     status;
      logic                     last;
   } store_rsp_type;

   class store_scoreboard;
      logic signed [DATA_W-1:0] cells[CAPACITY];
      int unsigned              fill;
      store_rsp_type            pending_rsp[$];
      int unsigned              errors;
      int unsigned              n_commands;
      int unsigned              n_inserts;
      int unsigned              n_rejected;
      int unsigned              n_reads;
      int unsigned              n_checked;
      int unsigned              peak_fill;

      function void expect_rsp(input logic signed [DATA_W-1:0] element,
                               input logic valid, input logic status,
                               input logic last);
         pending_rsp.push_back('{element, valid, CNT_W'(fill), status, last});
      endfunction

      // works out the results of one accepted command and updates the store
      function void note_command(input logic [MODE_W-1:0] mode,
                                 input logic signed [DATA_W-1:0] value);
         int unsigned pos;
         logic        full;
         n_commands++;
         full = 1'b0;
         case (mode)
            sis_pkg::MODE_APPEND, sis_pkg::MODE_HEAD, sis_pkg::MODE_SORTED: begin
               n_inserts++;
               if (fill >= CAPACITY) begin
                  full = 1'b1;
                  n_rejected++;
               end else begin
                  if (mode == sis_pkg::MODE_APPEND) begin
                     pos = fill;
                  end else if (mode == sis_pkg::MODE_HEAD) begin
                     pos = 0;
                  end else begin
                     // equal values go in front of the first equal element
                     pos = 0;
                     while (pos < fill && cells[pos] < value) pos++;
                  end
                  for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos] = value;
                  fill++;
                  if (fill > peak_fill) peak_fill = fill;
               end
            end
            sis_pkg::MODE_CLEAR: fill = 0;
            sis_pkg::MODE_READ: begin
               n_reads++;
               if (fill == 0) begin
                  expect_rsp('0, 1'b0, 1'b0, 1'b1);
               end else begin
                  for (int i = 0; i < fill; i++)
                     expect_rsp(cells[i], 1'b1, 1'b0, i == fill - 1);
               end
               return;
            end
            default: ;
         endcase
         expect_rsp('0, 1'b0, full, 1'b1);
      endfunction

      function void check_response(input store_rsp_type got);
         store_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: element %0d count %0d",
                   got.element, got.count);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         n_checked++;
         if (got.element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, got.element);
            errors++;
         end
         if (got.element_valid !== want.element_valid) begin
            $error("element_valid: expected %0b, got %0b",
                   want.element_valid, got.element_valid);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic [MODE_W-1:0]        req_mode  = sis_pkg::MODE_APPEND;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_element_valid;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_status;
   logic                     rsp_last;

   store_scoreboard sb = new();

   sorted_insert_sequence_store_core #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_element      (rsp_element),
      .rsp_element_valid(rsp_element_valid),
      .rsp_count        (rsp_count),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results first, so a result can never be matched to the command of its own edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response('{rsp_element, rsp_element_valid, rsp_count,
                                rsp_status, rsp_last});
         if (start && !busy) sb.note_command(req_mode, req_value);
      end
   end

   task automatic send(input logic [MODE_W-1:0] mode,
                       input logic signed [DATA_W-1:0] value);
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // the last transfer is noted at the edge that ends send, so look from the next one
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending_rsp.size() != 0);
   endtask

   task automatic random_command();
      int unsigned              pick;
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] value;
      pick = $urandom_range(99);
      // mostly inserts so the store fills up and full rejections happen often
      if (pick < 20)      mode = sis_pkg::MODE_APPEND;
      else if (pick < 40) mode = sis_pkg::MODE_HEAD;
      else if (pick < 68) mode = sis_pkg::MODE_SORTED;
      else if (pick < 88) mode = sis_pkg::MODE_READ;
      else if (pick < 93) mode = sis_pkg::MODE_CLEAR;
      else                mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      pick = $urandom_range(9);
      if (pick < 5)       value = $urandom;
      else if (pick < 8)  value = int'($urandom_range(8)) - 4;
      else if (pick == 8) value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      else if (sb.fill > 0 && sb.fill <= CAPACITY)
         value = sb.cells[$urandom_range(sb.fill - 1)];
      else
         value = '0;
      send(mode, value);
   endtask

   // idle_pct is the chance that the sender sits out any given cycle
   task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct);
      repeat (n_items) begin
         while ($urandom_range(99) < idle_pct) pause(1);
         random_command();
      end
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(sis_pkg::MODE_READ, VAL_MAX);
      send(sis_pkg::MODE_CLEAR, VAL_MIN);
      send(MODE_UNUSED_LO, '0);
      send(MODE_UNUSED_HI, '1);
      send(sis_pkg::MODE_SORTED, '0);
      send(sis_pkg::MODE_SORTED, VAL_MIN);
      send(sis_pkg::MODE_SORTED, VAL_MAX);
      send(sis_pkg::MODE_SORTED, '0);
      send(sis_pkg::MODE_SORTED, -1);
      send(sis_pkg::MODE_APPEND, VAL_MAX);
      send(sis_pkg::MODE_HEAD, VAL_MIN);
      send(sis_pkg::MODE_READ, '0);
      repeat (CAPACITY - 7) send(sis_pkg::MODE_SORTED, $urandom);
      send(sis_pkg::MODE_APPEND, 1);
      send(sis_pkg::MODE_HEAD, 2);
      send(sis_pkg::MODE_SORTED, 3);
      send(sis_pkg::MODE_READ, '0);
      send(sis_pkg::MODE_CLEAR, '0);
      send(sis_pkg::MODE_READ, '0);
      drain();

      run_phase(98, 29);
      run_phase(98, 77);
      run_phase(97, 0);
      repeat (20) @(posedge clock);

      $display("covered %0d commands: %0d inserts (%0d refused when full), %0d read outs",
               sb.n_commands, sb.n_inserts, sb.n_rejected, sb.n_reads);
      $display("checked %0d results, deepest fill %0d of %0d",
               sb.n_checked, sb.peak_fill, CAPACITY);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb failed");
      $finish;
   end

endmodule
